// ===== hw/rtl/ccan_pkg.sv =====
`timescale 1ns / 1ps

package ccan_pkg;

  localparam int SLOTS = 4;
  localparam int SUITS = 4;
  localparam int CARDS = 4;

  localparam int RANK_W = 4;
  localparam int SUIT_W = 2;
  localparam int WORD_W = SLOTS * RANK_W;

  // Horner partial over one bucket never exceeds 15 * (15^4 - 1) / 14 = 54240.
  localparam int PART_W = 16;
  // Widths of the running hash after two, three and four buckets.
  localparam int H1_W   = 32;
  localparam int H2_W   = 47;
  localparam int HASH_W = 63;

  localparam logic [3:0]  BASE  = 4'd15;
  localparam logic [15:0] BASE4 = 16'd50625;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [SUIT_W-1:0] suit_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PART_W-1:0] part_t;

  // Base-15 Horner value of the four slots of one bucket, top nibble first.
  function automatic part_t bucket_partial(input word_t w);
    part_t acc;
    acc = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      acc = PART_W'(acc * PART_W'(BASE)) + PART_W'(w[i*RANK_W +: RANK_W]);
    end
    return acc;
  endfunction

endpackage

// ===== hw/rtl/ccan_lane.sv =====
`timescale 1ns / 1ps

// One suit lane: keeps the ranks of the cards of its suit and sorts them
// in descending order. Cards of other suits enter as zero and sink to the end.
module ccan_lane
  import ccan_pkg::*;
(
  input  suit_t suit_id,
  input  suit_t card_suit [CARDS],
  input  rank_t card_rank [CARDS],
  output word_t word
);

  rank_t v0 [CARDS];
  rank_t v1 [CARDS];
  rank_t v2 [CARDS];
  rank_t v3 [CARDS];

  always_comb begin
    for (int k = 0; k < CARDS; k++) begin
      v0[k] = (card_suit[k] == suit_id) ? card_rank[k] : '0;
    end

    // Five-exchange network, larger value to the lower index.
    v1[0] = (v0[0] >= v0[1]) ? v0[0] : v0[1];
    v1[1] = (v0[0] >= v0[1]) ? v0[1] : v0[0];
    v1[2] = (v0[2] >= v0[3]) ? v0[2] : v0[3];
    v1[3] = (v0[2] >= v0[3]) ? v0[3] : v0[2];

    v2[0] = (v1[0] >= v1[2]) ? v1[0] : v1[2];
    v2[2] = (v1[0] >= v1[2]) ? v1[2] : v1[0];
    v2[1] = (v1[1] >= v1[3]) ? v1[1] : v1[3];
    v2[3] = (v1[1] >= v1[3]) ? v1[3] : v1[1];

    v3[0] = v2[0];
    v3[3] = v2[3];
    v3[1] = (v2[1] >= v2[2]) ? v2[1] : v2[2];
    v3[2] = (v2[1] >= v2[2]) ? v2[2] : v2[1];

    word = {v3[0], v3[1], v3[2], v3[3]};
  end

endmodule

// ===== hw/rtl/ccan_merge.sv =====
`timescale 1ns / 1ps

// Orders the lane buckets. With slot 0 in the top nibble, the lexicographic
// order of two buckets is the numeric order of their packed words.
module ccan_merge
  import ccan_pkg::*;
(
  input  word_t lane_word [SUITS],
  output word_t sorted    [SUITS],
  output part_t partial   [SUITS]
);

  word_t w1 [SUITS];
  word_t w2 [SUITS];

  always_comb begin
    w1[0] = (lane_word[0] >= lane_word[1]) ? lane_word[0] : lane_word[1];
    w1[1] = (lane_word[0] >= lane_word[1]) ? lane_word[1] : lane_word[0];
    w1[2] = (lane_word[2] >= lane_word[3]) ? lane_word[2] : lane_word[3];
    w1[3] = (lane_word[2] >= lane_word[3]) ? lane_word[3] : lane_word[2];

    w2[0] = (w1[0] >= w1[2]) ? w1[0] : w1[2];
    w2[2] = (w1[0] >= w1[2]) ? w1[2] : w1[0];
    w2[1] = (w1[1] >= w1[3]) ? w1[1] : w1[3];
    w2[3] = (w1[1] >= w1[3]) ? w1[3] : w1[1];

    sorted[0] = w2[0];
    sorted[3] = w2[3];
    sorted[1] = (w2[1] >= w2[2]) ? w2[1] : w2[2];
    sorted[2] = (w2[1] >= w2[2]) ? w2[2] : w2[1];

    for (int i = 0; i < SUITS; i++) begin
      partial[i] = bucket_partial(sorted[i]);
    end
  end

endmodule

// ===== hw/rtl/card_suit_canonicalizer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// hand      in         hand_valid / hand_stall   card0..3_suit, card0..3_rank
// canon     out        canon_valid / canon_stall bucket0..3_word, hand_hash
//
// Five pipeline stages: suit lanes, bucket merge, then three Horner stages;
// the first folds in two buckets, the others one each, one multiply by 15^4 per stage.
// One item enters every cycle while hand_stall is low.
// Each stage holds when the stage after it is full and stalled, so empty stages
// still fill while a result waits; hand_stall rises only when all five are full.
// rst is synchronous and clears the stage valid bits only.
module card_suit_canonicalizer_unit
  import ccan_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              hand_valid,
  output logic              hand_stall,
  input  logic [1:0]        card0_suit,
  input  logic [3:0]        card0_rank,
  input  logic [1:0]        card1_suit,
  input  logic [3:0]        card1_rank,
  input  logic [1:0]        card2_suit,
  input  logic [3:0]        card2_rank,
  input  logic [1:0]        card3_suit,
  input  logic [3:0]        card3_rank,
  output logic              canon_valid,
  input  logic              canon_stall,
  output logic [15:0]       bucket0_word,
  output logic [15:0]       bucket1_word,
  output logic [15:0]       bucket2_word,
  output logic [15:0]       bucket3_word,
  output logic [HASH_W-1:0] hand_hash
);

  localparam int STAGES = 5;

  logic [STAGES:1]   vld;
  logic [STAGES+1:1] rdy;

  suit_t card_suit [CARDS];
  rank_t card_rank [CARDS];
  word_t lane_word [SUITS];
  word_t sorted    [SUITS];
  part_t partial   [SUITS];

  // Stage registers.
  word_t       s1_word [SUITS];
  word_t       s2_word [SUITS];
  part_t       s2_part [SUITS];
  word_t       s3_word [SUITS];
  logic [H1_W-1:0] s3_hash;
  part_t       s3_part2;
  part_t       s3_part3;
  word_t       s4_word [SUITS];
  logic [H2_W-1:0] s4_hash;
  part_t       s4_part3;
  word_t       s5_word [SUITS];
  logic [HASH_W-1:0] s5_hash;

  logic [H1_W-1:0]   h1_next;
  logic [H2_W-1:0]   h2_next;
  logic [HASH_W-1:0] h3_next;

  assign card_suit[0] = card0_suit;
  assign card_suit[1] = card1_suit;
  assign card_suit[2] = card2_suit;
  assign card_suit[3] = card3_suit;
  assign card_rank[0] = card0_rank;
  assign card_rank[1] = card1_rank;
  assign card_rank[2] = card2_rank;
  assign card_rank[3] = card3_rank;

  for (genvar g = 0; g < SUITS; g++) begin : g_lane
    ccan_lane u_lane (
      .suit_id   (SUIT_W'(g)),
      .card_suit (card_suit),
      .card_rank (card_rank),
      .word      (lane_word[g])
    );
  end

  ccan_merge u_merge (
    .lane_word (s1_word),
    .sorted    (sorted),
    .partial   (partial)
  );

  // A stage can take an item when it is empty or its item moves on.
  always_comb begin
    rdy[STAGES+1] = !canon_stall;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign hand_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= hand_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    h1_next = H1_W'(H1_W'(s2_part[0]) * H1_W'(BASE4) + H1_W'(s2_part[1]));
    h2_next = H2_W'(H2_W'(s3_hash) * H2_W'(BASE4) + H2_W'(s3_part2));
    h3_next = HASH_W'(HASH_W'(s4_hash) * HASH_W'(BASE4) + HASH_W'(s4_part3));
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && hand_valid) begin
      s1_word <= lane_word;
    end
    if (rdy[2] && vld[1]) begin
      s2_word <= sorted;
      s2_part <= partial;
    end
    if (rdy[3] && vld[2]) begin
      s3_word  <= s2_word;
      s3_hash  <= h1_next;
      s3_part2 <= s2_part[2];
      s3_part3 <= s2_part[3];
    end
    if (rdy[4] && vld[3]) begin
      s4_word  <= s3_word;
      s4_hash  <= h2_next;
      s4_part3 <= s3_part3;
    end
    if (rdy[5] && vld[4]) begin
      s5_word <= s4_word;
      s5_hash <= h3_next;
    end
  end

  assign canon_valid  = vld[STAGES];
  assign bucket0_word = s5_word[0];
  assign bucket1_word = s5_word[1];
  assign bucket2_word = s5_word[2];
  assign bucket3_word = s5_word[3];
  assign hand_hash    = s5_hash;

`ifndef SYNTHESIS
  a_bucket_order: assert property (@(posedge clk) disable iff (rst)
    canon_valid |-> (bucket0_word >= bucket1_word) && (bucket1_word >= bucket2_word)
                    && (bucket2_word >= bucket3_word))
    else $error("canonical buckets out of order");

  a_no_stall_when_room: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> !hand_stall)
    else $error("input stalled while the first stage is empty");

  a_drain_on_take: assert property (@(posedge clk) disable iff (rst)
    (canon_valid && !canon_stall && !vld[STAGES-1]) |=> !canon_valid)
    else $error("result delivered twice");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !canon_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== dv/card_suit_canonicalizer_unit_test.sv =====
`timescale 1ns / 1ps

module card_suit_canonicalizer_unit_test;
  import ccan_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 32;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    suit_t [CARDS-1:0] suit;
    rank_t [CARDS-1:0] rank;
  } hand_t;

  typedef struct packed {
    word_t [SUITS-1:0]  word;
    logic [HASH_W-1:0]  hash;
  } canon_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              hand_valid = 1'b0;
  logic              hand_stall;
  logic [1:0]        card0_suit = '0;
  logic [3:0]        card0_rank = '0;
  logic [1:0]        card1_suit = '0;
  logic [3:0]        card1_rank = '0;
  logic [1:0]        card2_suit = '0;
  logic [3:0]        card2_rank = '0;
  logic [1:0]        card3_suit = '0;
  logic [3:0]        card3_rank = '0;
  logic              canon_valid;
  logic              canon_stall = 1'b0;
  logic [15:0]       bucket0_word;
  logic [15:0]       bucket1_word;
  logic [15:0]       bucket2_word;
  logic [15:0]       bucket3_word;
  logic [HASH_W-1:0] hand_hash;

  canon_t expected_canon_q[$];
  int     hands_sent = 0;
  int     canon_checked = 0;
  int     mismatches = 0;
  int     cycle_count = 0;
  int     send_idle_pct = IDLE_PCT;
  int     recv_idle_pct = IDLE_PCT;
  int     hold_req_seq = 0;
  int     hold_req_len = 0;

  card_suit_canonicalizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .hand_valid   (hand_valid),
    .hand_stall   (hand_stall),
    .card0_suit   (card0_suit),
    .card0_rank   (card0_rank),
    .card1_suit   (card1_suit),
    .card1_rank   (card1_rank),
    .card2_suit   (card2_suit),
    .card2_rank   (card2_rank),
    .card3_suit   (card3_suit),
    .card3_rank   (card3_rank),
    .canon_valid  (canon_valid),
    .canon_stall  (canon_stall),
    .bucket0_word (bucket0_word),
    .bucket1_word (bucket1_word),
    .bucket2_word (bucket2_word),
    .bucket3_word (bucket3_word),
    .hand_hash    (hand_hash)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sorts each card into its suit pile, orders the piles and folds the hash.
  function automatic canon_t canonicalize(input hand_t h);
    rank_t       pile[SUITS][SLOTS];
    word_t       w[SUITS];
    word_t       tmp;
    logic [63:0] acc;
    logic        placed;
    suit_t       s;
    rank_t       r;
    canon_t      c;
    for (int i = 0; i < SUITS; i++) begin
      for (int k = 0; k < SLOTS; k++) begin
        pile[i][k] = '0;
      end
    end
    for (int n = 0; n < CARDS; n++) begin
      s = h.suit[n];
      r = h.rank[n];
      placed = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        if (!placed) begin
          if (pile[s][k] == '0) begin
            pile[s][k] = r;
            placed = 1'b1;
          end else if (r > pile[s][k]) begin
            for (int j = SLOTS - 1; j > k; j--) begin
              pile[s][j] = pile[s][j-1];
            end
            pile[s][k] = r;
            placed = 1'b1;
          end
        end
      end
    end
    // With slot 0 in the top nibble, slot-wise order is plain numeric order.
    for (int i = 0; i < SUITS; i++) begin
      w[i] = {pile[i][0], pile[i][1], pile[i][2], pile[i][3]};
    end
    for (int i = 0; i < SUITS - 1; i++) begin
      for (int j = 0; j < SUITS - 1 - i; j++) begin
        if (w[j] < w[j+1]) begin
          tmp = w[j];
          w[j] = w[j+1];
          w[j+1] = tmp;
        end
      end
    end
    acc = '0;
    for (int i = 0; i < SUITS; i++) begin
      c.word[i] = w[i];
      for (int k = SLOTS - 1; k >= 0; k--) begin
        acc = acc * 64'd15 + 64'(w[i][k*RANK_W +: RANK_W]);
      end
    end
    c.hash = acc[HASH_W-1:0];
    return c;
  endfunction

  function automatic hand_t hand_of(input int s0, input int r0, input int s1, input int r1,
                                    input int s2, input int r2, input int s3, input int r3);
    hand_t h;
    h.suit[0] = suit_t'(s0);
    h.rank[0] = rank_t'(r0);
    h.suit[1] = suit_t'(s1);
    h.rank[1] = rank_t'(r1);
    h.suit[2] = suit_t'(s2);
    h.rank[2] = rank_t'(r2);
    h.suit[3] = suit_t'(s3);
    h.rank[3] = rank_t'(r3);
    return h;
  endfunction

  // Mostly legal ranks; a narrow suit spread makes equal and full piles common.
  function automatic hand_t random_hand();
    hand_t h;
    int    spread;
    int    base;
    spread = $urandom_range(4, 1);
    base = $urandom_range(3);
    for (int n = 0; n < CARDS; n++) begin
      h.suit[n] = suit_t'(base + $urandom_range(spread - 1));
      if ($urandom_range(99) < 8) begin
        h.rank[n] = $urandom_range(1) ? rank_t'(15) : rank_t'(0);
      end else begin
        h.rank[n] = rank_t'($urandom_range(14, 1));
      end
    end
    return h;
  endfunction

  task automatic send_hand(input hand_t h);
    hand_valid <= 1'b1;
    card0_suit <= h.suit[0];
    card0_rank <= h.rank[0];
    card1_suit <= h.suit[1];
    card1_rank <= h.rank[1];
    card2_suit <= h.suit[2];
    card2_rank <= h.rank[2];
    card3_suit <= h.suit[3];
    card3_rank <= h.rank[3];
    @(posedge clk);
    while (hand_stall) @(posedge clk);
    expected_canon_q.push_back(canonicalize(h));
    hands_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    hand_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_with_gaps(input hand_t h);
    if ($urandom_range(99) < send_idle_pct) begin
      pause_sender($urandom_range(2, 1));
    end
    send_hand(h);
  endtask

  task automatic test_full_and_empty_buckets();
    send_with_gaps(hand_of(3, 11, 3, 14, 3, 12, 3, 13));
    send_with_gaps(hand_of(0, 1, 1, 1, 2, 1, 3, 1));
    send_with_gaps(hand_of(2, 7, 2, 7, 2, 3, 2, 7));
    send_with_gaps(hand_of(1, 2, 1, 9, 1, 9, 1, 2));
    send_with_gaps(hand_of(3, 1, 2, 2, 1, 4, 0, 8));
  endtask

  // Zero ranks leave a pile untouched; rank fifteen is taken as ordinary.
  task automatic test_rank_extremes();
    send_with_gaps(hand_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_with_gaps(hand_of(1, 0, 1, 5, 1, 0, 2, 0));
    send_with_gaps(hand_of(0, 15, 0, 15, 0, 15, 0, 15));
    send_with_gaps(hand_of(0, 15, 1, 15, 2, 15, 3, 15));
    send_with_gaps(hand_of(3, 15, 3, 0, 3, 14, 3, 1));
    send_with_gaps(hand_of(2, 14, 2, 14, 2, 14, 2, 14));
    send_with_gaps(hand_of(1, 0, 1, 0, 1, 0, 1, 15));
  endtask

  task automatic test_bucket_ordering();
    send_with_gaps(hand_of(0, 9, 0, 4, 2, 4, 2, 9));
    send_with_gaps(hand_of(0, 9, 1, 8, 1, 8, 1, 8));
    send_with_gaps(hand_of(1, 9, 1, 2, 3, 3, 3, 9));
    send_with_gaps(hand_of(3, 5, 2, 5, 1, 5, 0, 6));
    send_with_gaps(hand_of(2, 10, 3, 10, 3, 1, 0, 10));
    send_with_gaps(hand_of(1, 6, 1, 5, 2, 6, 2, 5));
  endtask

  task automatic test_random_hands();
    for (int n = 0; n < 350; n++) begin
      send_with_gaps(random_hand());
    end
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int n = 0; n < 60; n++) begin
      send_hand(random_hand());
    end
    send_idle_pct = IDLE_PCT;
    recv_idle_pct <= IDLE_PCT;
  endtask

  // The output is held off long enough that every stage fills and input stalls.
  task automatic test_output_hold_off();
    hold_req_len <= 80;
    hold_req_seq <= hold_req_seq + 1;
    for (int n = 0; n < 30; n++) begin
      send_hand(random_hand());
    end
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) begin
      send_with_gaps(random_hand());
    end
    hand_valid <= 1'b0;
    while (expected_canon_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 20; n++) begin
      send_with_gaps(random_hand());
    end
  endtask

  always @(posedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_req_seq != hold_seen) begin
      hold_seen = hold_req_seq;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      canon_stall <= 1'b1;
      hold_left--;
    end else begin
      canon_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    canon_t got;
    canon_t want;
    if (!rst && canon_valid && !canon_stall) begin
      got.word[0] = bucket0_word;
      got.word[1] = bucket1_word;
      got.word[2] = bucket2_word;
      got.word[3] = bucket3_word;
      got.hash    = hand_hash;
      if (expected_canon_q.size() == 0) begin
        $error("canonical result with no hand outstanding");
        mismatches++;
      end else begin
        want = expected_canon_q.pop_front();
        canon_checked++;
        for (int i = 0; i < SUITS; i++) begin
          if (got.word[i] !== want.word[i]) begin
            $error("bucket%0d_word: expected %h, got %h", i, want.word[i], got.word[i]);
            mismatches++;
          end
        end
        if (got.hash !== want.hash) begin
          $error("hand_hash: expected %0d, got %0d", want.hash, got.hash);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_canon_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_full_and_empty_buckets();
    test_rank_extremes();
    test_bucket_ordering();
    test_random_hands();
    test_back_to_back();
    test_output_hold_off();
    test_drain_pause();
    hand_valid <= 1'b0;
    while (expected_canon_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_canon_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_canon_q.size());
      mismatches++;
    end
    $display("Checked %0d canonical results for %0d hands: full, empty and tied piles,",
             canon_checked, hands_sent);
    $display("zero and fifteen ranks, random idling, a long output hold-off and a drain.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ccan_pkg.sv
hw/rtl/ccan_lane.sv
hw/rtl/ccan_merge.sv
hw/rtl/card_suit_canonicalizer_unit.sv
dv/card_suit_canonicalizer_unit_test.sv
